FILE: rtl/core/evtmr_pkg.sv
// Package for the event timer: register offsets, item mode codes,
// configuration register indexes and capability reset values.
// Has no dependencies; used by event_timer_with_comparator.
package evtmr_pkg;

   typedef logic [1:0] mode_type;
   typedef logic [8:0] offset_type;
   typedef logic [2:0] csr_index_type;

   localparam mode_type MODE_TICK  = 2'd0;
   localparam mode_type MODE_READ  = 2'd1;
   localparam mode_type MODE_WRITE = 2'd2;

   localparam offset_type OFF_CAPS  = 9'd0;
   localparam offset_type OFF_GCFG  = 9'd16;
   localparam offset_type OFF_COUNT = 9'd240;
   localparam offset_type OFF_TCFG  = 9'd256;
   localparam offset_type OFF_CMP   = 9'd264;

   localparam csr_index_type CSR_PERIOD      = 3'd0;
   localparam csr_index_type CSR_COUNT_WIDE  = 3'd1;
   localparam csr_index_type CSR_LEGACY_CAP  = 3'd2;
   localparam csr_index_type CSR_CMP_WIDE    = 3'd3;
   localparam csr_index_type CSR_ROUTE_MASK  = 3'd4;

   localparam int CSR_DATA_BITS = 32;
   localparam int PERIOD_BITS   = 27;
   localparam int ROUTE_BITS    = 5;

   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET     = 27'd69841279;
   localparam logic [31:0]            ROUTE_MASK_RESET = 32'd4;
   localparam logic [63:0]            LOW32_MASK       = 64'h0000_0000_FFFF_FFFF;

endpackage

FILE: rtl/core/event_timer_with_comparator.sv
// Event timer with one comparator: main counter, general and timer config,
// comparator, and the register file that a driver reads and writes.
// Depends on evtmr_pkg.
//
// Each result word appears in the cycle after its word is accepted.
// Throughput: one word per cycle while rsp_ready is high; the counter add
// and comparator match sit between request handshake and result register.
// Reset (synchronous, active high) clears the timer state, sets the
// comparator to all ones and restores the capability registers.
module event_timer_with_comparator
   import evtmr_pkg::*;
#(
   parameter int COUNTER_BITS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_mode,
   input  logic [8:0]               req_reg_offset,
   input  logic [63:0]              req_write_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [63:0]              rsp_read_data,
   output logic                     rsp_irq_fire,
   output logic [4:0]               rsp_irq_line,
   input  logic                     csr_wr_en,
   input  logic [2:0]               csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wr_data
);

   localparam logic [COUNTER_BITS-1:0] CNT_LOW32 = COUNTER_BITS'(LOW32_MASK);

   // Capability registers
   logic [PERIOD_BITS-1:0]   period_ff;
   logic                     cnt_wide_cap_ff;
   logic                     legacy_cap_ff;
   logic                     cmp_wide_cap_ff;
   logic [31:0]              route_mask_ff;

   // Timer state
   logic [COUNTER_BITS-1:0]  count_ff, count_in;
   logic                     cnt_en_ff, cnt_en_in;
   logic                     legacy_en_ff, legacy_en_in;
   logic                     int_en_ff, int_en_in;
   logic                     force_narrow_ff, force_narrow_in;
   logic [ROUTE_BITS-1:0]    route_ff, route_in;
   logic                     fsb_en_ff, fsb_en_in;
   logic [63:0]              compare_ff, compare_in;

   // Result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [63:0]              read_data_ff, read_data_in;
   logic                     irq_fire_ff, irq_fire_in;
   logic [ROUTE_BITS-1:0]    irq_line_ff, irq_line_in;

   logic                     accept;
   logic [COUNTER_BITS-1:0]  cnt_mask;
   logic [63:0]              cmp_mask;
   logic [COUNTER_BITS-1:0]  count_inc;
   logic [63:0]              reg_value;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;

   assign cnt_mask  = cnt_wide_cap_ff ? '1 : CNT_LOW32;
   assign cmp_mask  = (force_narrow_ff || !cmp_wide_cap_ff) ? LOW32_MASK : '1;
   assign count_inc = (count_ff + 1'b1) & cnt_mask;

   // Register read decode
   always_comb begin
      reg_value = '0;
      case (req_reg_offset)
         OFF_CAPS: begin
            reg_value[63:32] = 32'(period_ff);
            reg_value[13]    = cnt_wide_cap_ff;
            reg_value[15]    = legacy_cap_ff;
         end
         OFF_GCFG: begin
            reg_value[0] = cnt_en_ff;
            reg_value[1] = legacy_en_ff;
         end
         OFF_COUNT: begin
            reg_value = 64'(count_ff & cnt_mask);
         end
         OFF_TCFG: begin
            reg_value[2]     = int_en_ff;
            reg_value[5]     = cmp_wide_cap_ff;
            reg_value[8]     = force_narrow_ff;
            reg_value[13:9]  = route_ff;
            reg_value[14]    = fsb_en_ff;
            reg_value[63:32] = route_mask_ff;
         end
         OFF_CMP: begin
            reg_value = compare_ff & cmp_mask;
         end
         default: begin
            reg_value = '0;
         end
      endcase
   end

   always_comb begin
      count_in        = count_ff;
      cnt_en_in       = cnt_en_ff;
      legacy_en_in    = legacy_en_ff;
      int_en_in       = int_en_ff;
      force_narrow_in = force_narrow_ff;
      route_in        = route_ff;
      fsb_en_in       = fsb_en_ff;
      compare_in      = compare_ff;
      read_data_in    = read_data_ff;
      irq_fire_in     = irq_fire_ff;
      irq_line_in     = irq_line_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;

      if (accept) begin
         rsp_valid_in = 1'b1;
         read_data_in = '0;
         irq_fire_in  = 1'b0;
         irq_line_in  = '0;
         case (req_mode)
            MODE_TICK: begin
               if (cnt_en_ff) begin
                  count_in = count_inc;
                  // The match uses the counter value after this tick.
                  if (int_en_ff &&
                      ((64'(count_inc) & cmp_mask) == (compare_ff & cmp_mask))) begin
                     irq_fire_in = 1'b1;
                     irq_line_in = legacy_en_ff ? '0 : route_ff;
                  end
               end
            end
            MODE_READ: begin
               read_data_in = reg_value;
            end
            MODE_WRITE: begin
               case (req_reg_offset)
                  OFF_GCFG: begin
                     cnt_en_in    = req_write_data[0];
                     legacy_en_in = legacy_cap_ff && req_write_data[1];
                  end
                  OFF_COUNT: begin
                     count_in = req_write_data[COUNTER_BITS-1:0] & cnt_mask;
                  end
                  OFF_TCFG: begin
                     int_en_in       = req_write_data[2];
                     force_narrow_in = req_write_data[8];
                     route_in        = req_write_data[13:9];
                     fsb_en_in       = req_write_data[14];
                  end
                  OFF_CMP: begin
                     compare_in = req_write_data & cmp_mask;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff       <= PERIOD_RESET;
         cnt_wide_cap_ff <= 1'b1;
         legacy_cap_ff   <= 1'b1;
         cmp_wide_cap_ff <= 1'b1;
         route_mask_ff   <= ROUTE_MASK_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PERIOD:     period_ff       <= csr_wr_data[PERIOD_BITS-1:0];
            CSR_COUNT_WIDE: cnt_wide_cap_ff <= csr_wr_data[0];
            CSR_LEGACY_CAP: legacy_cap_ff   <= csr_wr_data[0];
            CSR_CMP_WIDE:   cmp_wide_cap_ff <= csr_wr_data[0];
            CSR_ROUTE_MASK: route_mask_ff   <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff        <= '0;
         cnt_en_ff       <= 1'b0;
         legacy_en_ff    <= 1'b0;
         int_en_ff       <= 1'b0;
         force_narrow_ff <= 1'b0;
         route_ff        <= '0;
         fsb_en_ff       <= 1'b0;
         compare_ff      <= '1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         count_ff        <= count_in;
         cnt_en_ff       <= cnt_en_in;
         legacy_en_ff    <= legacy_en_in;
         int_en_ff       <= int_en_in;
         force_narrow_ff <= force_narrow_in;
         route_ff        <= route_in;
         fsb_en_ff       <= fsb_en_in;
         compare_ff      <= compare_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      read_data_ff <= read_data_in;
      irq_fire_ff  <= irq_fire_in;
      irq_line_ff  <= irq_line_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = read_data_ff;
   assign rsp_irq_fire  = irq_fire_ff;
   assign rsp_irq_line  = irq_line_ff;

endmodule

FILE: tb/sv/tb_event_timer_with_comparator.sv
// Self-checking testbench for event_timer_with_comparator: directed register and
// comparator cases, then phased random traffic under random stalls on both sides.
// Depends on evtmr_pkg and the event_timer_with_comparator RTL.
module tb_event_timer_with_comparator;
   import evtmr_pkg::*;

   localparam int COUNTER_BITS = 64;
   localparam int LONG_HOLD    = 200;

   localparam mode_type   MODE_UNUSED  = 2'd3;
   localparam offset_type OFF_HOLE     = 9'd8;
   localparam offset_type OFF_TOP      = 9'd511;

   typedef struct packed {
      logic [63:0] read_data;
      logic        irq_fire;
      logic [4:0]  irq_line;
   } timer_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [1:0]               req_mode = MODE_TICK;
   logic [8:0]               req_reg_offset = OFF_CAPS;
   logic [63:0]              req_write_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [63:0]              rsp_read_data;
   logic                     rsp_irq_fire;
   logic [4:0]               rsp_irq_line;
   logic                     csr_wr_en = 1'b0;
   logic [2:0]               csr_index = CSR_PERIOD;
   logic [CSR_DATA_BITS-1:0] csr_wr_data = '0;

   // Predicted device state, kept in step with every accepted word.
   logic [PERIOD_BITS-1:0] cap_period     = PERIOD_RESET;
   logic                   cap_count_wide = 1'b1;
   logic                   cap_legacy     = 1'b1;
   logic                   cap_cmp_wide   = 1'b1;
   logic [31:0]            cap_route_mask = ROUTE_MASK_RESET;
   logic [63:0]            main_count_q   = '0;
   logic                   count_on       = 1'b0;
   logic                   legacy_on      = 1'b0;
   logic                   tmr_int_en     = 1'b0;
   logic                   tmr_narrow     = 1'b0;
   logic [4:0]             tmr_route      = '0;
   logic                   tmr_fsb        = 1'b0;
   logic [63:0]            cmp_value      = '1;

   timer_result_type expected_results[$];
   int            mismatch_count = 0;
   bit            tx_gaps_on = 1'b1;
   bit            rx_gaps_on = 1'b1;
   bit            hold_output = 1'b0;

   event_timer_with_comparator #(
      .COUNTER_BITS(COUNTER_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_reg_offset(req_reg_offset),
      .req_write_data(req_write_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_data(rsp_read_data),
      .rsp_irq_fire(rsp_irq_fire),
      .rsp_irq_line(rsp_irq_line),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   always #10 clock = ~clock;

   function automatic logic [63:0] count_mask();
      if (!cap_count_wide) return LOW32_MASK;
      if (COUNTER_BITS >= 64) return {64{1'b1}};
      return (64'd1 << COUNTER_BITS) - 64'd1;
   endfunction

   function automatic logic [63:0] cmp_mask();
      return (tmr_narrow || !cap_cmp_wide) ? LOW32_MASK : {64{1'b1}};
   endfunction

   // Applies one word to the predicted state and returns the word it answers with.
   function automatic timer_result_type predict_word(input mode_type m, input offset_type o,
                                                     input logic [63:0] d);
      timer_result_type r;
      logic [63:0]   cm;
      r = '0;
      cm = cmp_mask();
      case (m)
         MODE_TICK: begin
            if (count_on) begin
               main_count_q = (main_count_q + 64'd1) & count_mask();
               if (tmr_int_en && ((main_count_q & cm) == (cmp_value & cm))) begin
                  r.irq_fire = 1'b1;
                  r.irq_line = legacy_on ? 5'd0 : tmr_route;
               end
            end
         end
         MODE_READ: begin
            case (o)
               OFF_CAPS: begin
                  r.read_data[63:32] = {5'd0, cap_period};
                  r.read_data[13]    = cap_count_wide;
                  r.read_data[15]    = cap_legacy;
               end
               OFF_GCFG: r.read_data[1:0] = {legacy_on, count_on};
               OFF_COUNT: r.read_data = main_count_q & count_mask();
               OFF_TCFG: begin
                  r.read_data[2]     = tmr_int_en;
                  r.read_data[5]     = cap_cmp_wide;
                  r.read_data[8]     = tmr_narrow;
                  r.read_data[13:9]  = tmr_route;
                  r.read_data[14]    = tmr_fsb;
                  r.read_data[63:32] = cap_route_mask;
               end
               OFF_CMP: r.read_data = cmp_value & cm;
               default: r.read_data = '0;
            endcase
         end
         MODE_WRITE: begin
            case (o)
               OFF_GCFG: begin
                  count_on  = d[0];
                  legacy_on = cap_legacy ? d[1] : 1'b0;
               end
               OFF_COUNT: main_count_q = d & count_mask();
               OFF_TCFG: begin
                  tmr_int_en = d[2];
                  tmr_narrow = d[8];
                  tmr_route  = d[13:9];
                  tmr_fsb    = d[14];
               end
               OFF_CMP: cmp_value = d & cm;
               default: ;
            endcase
         end
         default: ;
      endcase
      return r;
   endfunction

   // Mostly back to back, sometimes a few cycles, now and then a long pause.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic offset_type known_offset();
      case ($urandom_range(0, 4))
         0: return OFF_CAPS;
         1: return OFF_GCFG;
         2: return OFF_COUNT;
         3: return OFF_TCFG;
         default: return OFF_CMP;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic send_word(input mode_type m, input offset_type o, input logic [63:0] d);
      int gap;
      gap = tx_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= m;
      req_reg_offset <= o;
      req_write_data <= d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_results.push_back(predict_word(m, o, d));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Writes all capability registers; junk above narrow fields must be dropped.
   task automatic set_caps(input logic [PERIOD_BITS-1:0] period, input logic cw,
                           input logic lc, input logic cmpw, input logic [31:0] mask);
      logic [31:0] junk;
      junk = $urandom;
      cap_period     = period;
      cap_count_wide = cw;
      cap_legacy     = lc;
      cap_cmp_wide   = cmpw;
      cap_route_mask = mask;
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_PERIOD;
      csr_wr_data <= {junk[31:PERIOD_BITS], period};
      @(posedge clock);
      csr_index   <= CSR_COUNT_WIDE;
      csr_wr_data <= {junk[31:1], cw};
      @(posedge clock);
      csr_index   <= CSR_LEGACY_CAP;
      csr_wr_data <= {junk[30:0], lc};
      @(posedge clock);
      csr_index   <= CSR_CMP_WIDE;
      csr_wr_data <= {junk[29:0], junk[31], cmpw};
      @(posedge clock);
      csr_index   <= CSR_ROUTE_MASK;
      csr_wr_data <= mask;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Random word, biased so the comparator often sits a few ticks ahead of the counter.
   task automatic random_word();
      int          r;
      logic [63:0] d;
      offset_type  o;
      d = {$urandom, $urandom};
      o = offset_type'($urandom_range(0, 511));
      r = $urandom_range(0, 99);
      if (r < 50) begin
         send_word(MODE_TICK, o, d);
      end else if (r < 65) begin
         send_word(MODE_READ, known_offset(), d);
      end else if (r < 69) begin
         send_word(MODE_READ, o, d);
      end else if (r < 74) begin
         d[0] = ($urandom_range(0, 9) != 0);
         send_word(MODE_WRITE, OFF_GCFG, d);
      end else if (r < 78) begin
         d[2] = ($urandom_range(0, 7) != 0);
         send_word(MODE_WRITE, OFF_TCFG, d);
      end else if (r < 86) begin
         d = main_count_q + $urandom_range(1, 12);
         if ($urandom_range(0, 3) == 0) d[63:32] = $urandom;
         send_word(MODE_WRITE, OFF_CMP, d);
      end else if (r < 90) begin
         case ($urandom_range(0, 2))
            0: d = cmp_value - $urandom_range(1, 12);
            1: d = LOW32_MASK - $urandom_range(0, 6);
            default: d = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 6);
         endcase
         send_word(MODE_WRITE, OFF_COUNT, d);
      end else if (r < 94) begin
         send_word(MODE_WRITE, known_offset(), d);
      end else if (r < 97) begin
         send_word(MODE_WRITE, o, d);
      end else begin
         send_word(MODE_UNUSED, o, d);
      end
   endtask

   task automatic test_register_access();
      send_word(MODE_READ, OFF_CAPS, '0);
      send_word(MODE_READ, OFF_TCFG, '0);
      send_word(MODE_READ, OFF_CMP, '0);
      send_word(MODE_WRITE, OFF_CAPS, '1);
      // All ones sets every writable timer bit, a route outside the mask and narrow mode.
      send_word(MODE_WRITE, OFF_TCFG, '1);
      send_word(MODE_READ, OFF_TCFG, '0);
      send_word(MODE_READ, OFF_CMP, '0);
      send_word(MODE_WRITE, OFF_HOLE, '1);
      send_word(MODE_READ, OFF_TOP, '1);
      send_word(MODE_UNUSED, OFF_CMP, '1);
   endtask

   task automatic test_compare_match();
      send_word(MODE_WRITE, OFF_TCFG, 64'h0000_0000_0000_1204);
      send_word(MODE_WRITE, OFF_CMP, 64'h0000_0001_0000_0002);
      send_word(MODE_TICK, OFF_CAPS, '0);
      send_word(MODE_WRITE, OFF_GCFG, 64'h1);
      send_word(MODE_WRITE, OFF_COUNT, 64'h0000_0001_0000_0000);
      send_word(MODE_TICK, OFF_CAPS, '0);
      send_word(MODE_TICK, OFF_CAPS, '0);
      send_word(MODE_WRITE, OFF_GCFG, 64'h3);
      send_word(MODE_WRITE, OFF_COUNT, '1);
      send_word(MODE_WRITE, OFF_CMP, '0);
      send_word(MODE_TICK, OFF_CAPS, '0);
      send_word(MODE_READ, OFF_COUNT, '0);
   endtask

   task automatic test_narrow_comparator();
      wait_idle();
      set_caps(27'd1, 1'b0, 1'b1, 1'b0, ROUTE_MASK_RESET);
      send_word(MODE_WRITE, OFF_CMP, 64'hABCD_0000_0000_0005);
      send_word(MODE_READ, OFF_CMP, '0);
      send_word(MODE_WRITE, OFF_COUNT, 64'h1234_5678_FFFF_FFFF);
      send_word(MODE_TICK, OFF_CAPS, '0);
      send_word(MODE_WRITE, OFF_COUNT, 64'h4);
      send_word(MODE_TICK, OFF_CAPS, '0);
      wait_idle();
      set_caps(PERIOD_RESET, 1'b1, 1'b1, 1'b1, ROUTE_MASK_RESET);
      send_word(MODE_WRITE, OFF_TCFG, 64'h0000_0000_0000_1304);
      send_word(MODE_WRITE, OFF_CMP, 64'hFFFF_FFFF_0000_0007);
      send_word(MODE_WRITE, OFF_COUNT, 64'h0000_0005_0000_0006);
      send_word(MODE_TICK, OFF_CAPS, '0);
   endtask

   // A legacy bit set while capable survives withdrawal until the next config write.
   task automatic test_legacy_withdrawal();
      wait_idle();
      set_caps(27'd100000000, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF);
      send_word(MODE_READ, OFF_CAPS, '0);
      send_word(MODE_READ, OFF_GCFG, '0);
      send_word(MODE_WRITE, OFF_GCFG, 64'h3);
      send_word(MODE_READ, OFF_GCFG, '0);
   endtask

   task automatic test_output_stall();
      hold_output = 1'b1;
      tx_gaps_on  = 1'b0;
      repeat (40) random_word();
      tx_gaps_on  = 1'b1;
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 6; phase++) begin
         wait_idle();
         case (phase)
            0: set_caps(27'd1, 1'b0, 1'b0, 1'b0, 32'h0);
            1: set_caps(27'd100000000, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
            default: set_caps(PERIOD_BITS'($urandom_range(1, 100000000)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), $urandom);
         endcase
         tx_gaps_on = (phase != 2 && phase != 4);
         rx_gaps_on = (phase != 3 && phase != 4);
         send_word(MODE_WRITE, OFF_GCFG, {$urandom, $urandom} | 64'h1);
         repeat (62) random_word();
      end
      tx_gaps_on = 1'b1;
      rx_gaps_on = 1'b1;
   endtask

   initial begin : result_drain
      int stall;
      @(posedge clock);
      forever begin
         stall = 0;
         if (hold_output) begin
            hold_output = 1'b0;
            stall = LONG_HOLD;
         end else if (rx_gaps_on && $urandom_range(0, 2) == 0) begin
            stall = pick_gap();
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin : result_check
      timer_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("word with nothing pending", rsp_read_data, '0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_read_data !== want.read_data)
               report_mismatch("read_data", rsp_read_data, want.read_data);
            if (rsp_irq_fire !== want.irq_fire)
               report_mismatch("irq_fire", 64'(rsp_irq_fire), 64'(want.irq_fire));
            if (rsp_irq_line !== want.irq_line)
               report_mismatch("irq_line", 64'(rsp_irq_line), 64'(want.irq_line));
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_register_access();
      test_compare_match();
      test_narrow_comparator();
      test_legacy_withdrawal();
      test_output_stall();
      test_random_traffic();
      wait_idle();
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #5000000;
      $display("timeout with %0d words pending", expected_results.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
